/* rtl/core/clamped_histogram_with_cuts_assert.svh */
// ----------------------------------------------------------------------------
// clamped_histogram_with_cuts_assert.svh
// Assertion macros for the histogram engine. They compile to nothing when
// SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef CLAMPED_HISTOGRAM_WITH_CUTS_ASSERT_SVH
`define CLAMPED_HISTOGRAM_WITH_CUTS_ASSERT_SVH
`ifndef SYNTHESIS
// Same-cycle implication, checked on every rising edge outside reset.
`define CHC_ASSERT_IMP(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("histogram engine: assertion failed");
// Next-cycle implication, checked on every rising edge outside reset.
`define CHC_ASSERT_NXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("histogram engine: assertion failed");
`else
`define CHC_ASSERT_IMP(name, ante, cons)
`define CHC_ASSERT_NXT(name, ante, cons)
`endif
`endif

/* rtl/core/chc_pkg.sv */
// ----------------------------------------------------------------------------
// chc_pkg
// Shared sizes, types and codes of the histogram engine.
// ----------------------------------------------------------------------------
package chc_pkg;

  localparam int MAX_BINS   = 1024;
  localparam int ADDR_W     = $clog2(MAX_BINS);
  localparam int BINS_W     = ADDR_W + 1;
  localparam int COUNT_W    = 32;
  localparam int TOTAL_W    = 40;
  localparam int SUM_W      = COUNT_W + ADDR_W;
  localparam int Q_W        = 32;
  localparam int PROD_W     = 2 * Q_W;
  localparam int IN_DATA_W  = 48;
  localparam int OUT_DATA_W = 56;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 40;

  typedef logic [ADDR_W-1:0]  addr_t;
  typedef logic [BINS_W-1:0]  bins_t;
  typedef logic [COUNT_W-1:0] count_t;
  typedef logic [TOTAL_W-1:0] total_t;
  typedef logic [SUM_W-1:0]   sum_t;
  typedef logic [Q_W-1:0]     q_t;
  typedef logic [PROD_W-1:0]  prod_t;

  localparam addr_t ADDR_LAST   = addr_t'(MAX_BINS - 1);
  localparam bins_t BINS_MIN    = bins_t'(2);
  localparam bins_t BINS_MAX    = bins_t'(MAX_BINS);
  localparam bins_t BINS_RESET  = bins_t'(256);
  localparam q_t    SCALE_RESET = q_t'(65536);
  localparam prod_t ROUND_HALF  = prod_t'(64'h0000_0000_8000_0000);

  typedef enum logic [1:0] {
    FUNC_ADD   = 2'd0,
    FUNC_READ  = 2'd1,
    FUNC_CUTS  = 2'd2,
    FUNC_CLEAR = 2'd3
  } func_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MIN_VALUE      = 3'd0,
    CFG_BIN_SCALE      = 3'd1,
    CFG_BINS_IN_USE    = 3'd2,
    CFG_KEEP_ZERO_BIN  = 3'd3,
    CFG_CUT_LOW_COUNT  = 3'd4,
    CFG_CUT_HIGH_COUNT = 3'd5
  } cfg_reg_t;

endpackage

/* rtl/core/clamped_histogram_with_cuts.sv */
// ----------------------------------------------------------------------------
// clamped_histogram_with_cuts
// Histogram engine for signed Q16.16 voxel values, with read-back, zero-bin
// correction, percentile cut search and clear, built around one bin memory.
//
// Each input word carries a function in in_tuser. An add word bins its sample
// as floor((sample - min_value) * bin_scale + 0.5), clamped to the bins in use,
// and increments that bin with saturation; adds stream at one word per cycle
// while the engine is idle, through a four-stage read-modify-write pipeline
// (subtract, multiply, round and memory read, increment and write back) in
// which a one-entry bypass covers back-to-back adds to the same bin. Adds give
// no result word. A read, find-cuts or clear word first waits until the add
// pipeline has drained and, for the two that return a word, until the output
// register is empty. A read goes through a drain check, a multiply for the
// zero-bin position, a compare and a memory read; a second memory read is made
// when the zero bin is rebuilt as the mean of its two neighbours, and no read
// at all when the bin lies beyond the bins in use. Find cuts walks the bins
// from the low end and then from the high end, with an address step and a
// compare step for each bin visited, as the memory has a single read port.
// Clear writes zero into all 1024 entries, one a cycle; the same sweep runs
// after reset, and in_tready stays low until it ends. Results wait in an
// output register, so adds are still taken while a result word is pending.
// Configuration writes are taken in any cycle and are meant for an idle engine.
// ----------------------------------------------------------------------------
`include "clamped_histogram_with_cuts_assert.svh"

module clamped_histogram_with_cuts (
  input  logic                           clk,
  input  logic                           rst_n,
  // Input words.
  input  logic                           in_tvalid,
  output logic                           in_tready,
  // [31:0] sample (signed Q16.16), [41:32] bin_index, [47:42] zero.
  input  logic [chc_pkg::IN_DATA_W-1:0]  in_tdata,
  // [1:0] func.
  input  logic [1:0]                     in_tuser,
  // Result words.
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // [31:0] bin_count, [41:32] low_cut_bin, [51:42] high_cut_bin,
  // [52] cut_applies, [55:53] zero.
  output logic [chc_pkg::OUT_DATA_W-1:0] out_tdata,
  // Configuration writes.
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [chc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [chc_pkg::CFG_DATA_W-1:0] cfg_data
);

  typedef enum logic [10:0] {
    S_IDLE  = 11'b000_0000_0001,
    S_CLR   = 11'b000_0000_0010,
    S_DRAIN = 11'b000_0000_0100,
    S_RMUL  = 11'b000_0000_1000,
    S_RZ    = 11'b000_0001_0000,
    S_RD1   = 11'b000_0010_0000,
    S_RD2   = 11'b000_0100_0000,
    S_LO_A  = 11'b000_1000_0000,
    S_LO_B  = 11'b001_0000_0000,
    S_HI_A  = 11'b010_0000_0000,
    S_HI_B  = 11'b100_0000_0000
  } state_t;

  // Configuration registers. min_r holds a signed Q16.16 value as raw bits.
  chc_pkg::q_t     min_r;
  chc_pkg::q_t     scale_r;
  chc_pkg::bins_t  bins_cfg_r;
  logic            keep_r;
  chc_pkg::total_t cut_lo_r;
  chc_pkg::total_t cut_hi_r;

  // Control and walk state.
  state_t          state_r, state_nxt;
  chc_pkg::addr_t  cnt_r, cnt_nxt;
  chc_pkg::sum_t   sum_r, sum_nxt;
  chc_pkg::addr_t  lo_r, lo_nxt;
  chc_pkg::count_t acc_r, acc_nxt;
  logic            pair_r, pair_nxt;
  chc_pkg::addr_t  z_r, z_nxt;
  chc_pkg::func_t  func_r, func_nxt;
  chc_pkg::addr_t  idx_r, idx_nxt;
  chc_pkg::total_t total_r, total_nxt;

  // Add pipeline.
  chc_pkg::q_t     mul_a_r, mul_a_nxt;
  chc_pkg::prod_t  prod_r;
  logic            vb_r, vb_nxt;
  logic            vc_r;
  logic            vd_r;
  chc_pkg::addr_t  d_addr_r;
  logic            fwd_v_r;
  chc_pkg::addr_t  fwd_addr_r;
  chc_pkg::count_t fwd_data_r;

  // Bin memory.
  chc_pkg::count_t mem [chc_pkg::MAX_BINS];
  chc_pkg::count_t rd_data_r;
  logic            mem_we;
  chc_pkg::addr_t  mem_wa;
  chc_pkg::count_t mem_wd;
  chc_pkg::addr_t  mem_ra;
  chc_pkg::addr_t  fsm_ra;

  // Result register.
  logic            out_valid_r;
  chc_pkg::count_t out_count_r;
  chc_pkg::addr_t  out_lo_r;
  chc_pkg::addr_t  out_hi_r;
  logic            out_cut_r;
  logic            out_load;
  chc_pkg::count_t res_count;
  chc_pkg::addr_t  res_lo;
  chc_pkg::addr_t  res_hi;
  logic            res_cut;

  // Datapath helpers.
  logic            in_acc;
  chc_pkg::func_t  in_func;
  logic [32:0]     diff;
  chc_pkg::q_t     dpos;
  chc_pkg::q_t     min_abs;
  logic            min_pos;
  chc_pkg::bins_t  bins_w;
  chc_pkg::addr_t  bins_m1;
  chc_pkg::prod_t  rnd_sum;
  chc_pkg::q_t     rnd_w;
  chc_pkg::addr_t  add_bin;
  chc_pkg::count_t old_count;
  chc_pkg::count_t inc_count;
  logic            zvalid;
  chc_pkg::addr_t  zidx;
  logic            zhit;
  chc_pkg::sum_t   walk_sum;
  chc_pkg::addr_t  hi_j;
  logic            pipe_empty;
  logic [chc_pkg::TOTAL_W:0] cut_sum;

  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign in_func   = chc_pkg::func_t'(in_tuser);
  assign cfg_ready = 1'b1;

  // Bins in use, held to the range the memory supports.
  always_comb begin
    if (bins_cfg_r < chc_pkg::BINS_MIN) begin
      bins_w = chc_pkg::BINS_MIN;
    end else if (bins_cfg_r > chc_pkg::BINS_MAX) begin
      bins_w = chc_pkg::BINS_MAX;
    end else begin
      bins_w = bins_cfg_r;
    end
  end
  assign bins_m1 = chc_pkg::addr_t'(bins_w - chc_pkg::bins_t'(1));

  // Stage one: the difference to min_value. Anything not above zero lands in
  // bin zero, so it simply enters the multiplier as zero.
  assign diff = {in_tdata[31], in_tdata[31:0]} - {min_r[31], min_r};
  assign dpos = (!diff[32] && (diff != '0)) ? diff[31:0] : '0;

  // Magnitude of min_value, the multiplier operand for the zero-bin position.
  assign min_abs = min_r[31] ? (~min_r + chc_pkg::q_t'(1)) : min_r;
  assign min_pos = !min_r[31] && (min_r != '0);

  // Stage three: round the Q32.32 product half up and clamp to the last bin.
  assign rnd_sum = prod_r + chc_pkg::ROUND_HALF;
  assign rnd_w   = rnd_sum[chc_pkg::PROD_W-1:chc_pkg::Q_W];
  assign add_bin = (rnd_w > chc_pkg::q_t'(bins_m1)) ? bins_m1 : rnd_w[chc_pkg::ADDR_W-1:0];

  // Stage four: the count read last cycle, or the one written last cycle when
  // the previous add hit the same bin, plus one with saturation.
  assign old_count = (fwd_v_r && (fwd_addr_r == d_addr_r)) ? fwd_data_r : rd_data_r;
  assign inc_count = (&old_count) ? old_count : old_count + chc_pkg::count_t'(1);

  // Zero-bin position, taken from the product of |min_value| and bin_scale.
  // A positive min_value puts the value zero below bin zero; it still rounds
  // into bin zero while the product stays within half a bin.
  always_comb begin
    if (min_pos) begin
      zvalid = (prod_r <= chc_pkg::prod_t'(32'h8000_0000));
      zidx   = '0;
    end else begin
      zvalid = (rnd_w < chc_pkg::q_t'(bins_w));
      zidx   = rnd_w[chc_pkg::ADDR_W-1:0];
    end
  end
  assign zhit = !keep_r && zvalid && (zidx == idx_r);

  assign walk_sum   = sum_r + chc_pkg::sum_t'(rd_data_r);
  assign hi_j       = bins_m1 - cnt_r;
  assign pipe_empty = !vb_r && !vc_r && !vd_r;
  assign cut_sum    = {1'b0, cut_lo_r} + {1'b0, cut_hi_r};

  // Sequencer for reads, the cut walk and the clearing sweep.
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    sum_nxt   = sum_r;
    lo_nxt    = lo_r;
    acc_nxt   = acc_r;
    pair_nxt  = pair_r;
    z_nxt     = z_r;
    func_nxt  = func_r;
    idx_nxt   = idx_r;
    total_nxt = total_r;
    mul_a_nxt = mul_a_r;
    vb_nxt    = 1'b0;
    fsm_ra    = idx_r;
    out_load  = 1'b0;
    res_count = '0;
    res_lo    = '0;
    res_hi    = '0;
    res_cut   = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          if (in_func == chc_pkg::FUNC_ADD) begin
            mul_a_nxt = dpos;
            vb_nxt    = 1'b1;
            if (!(&total_r)) begin
              total_nxt = total_r + chc_pkg::total_t'(1);
            end
          end else begin
            func_nxt  = in_func;
            idx_nxt   = in_tdata[41:32];
            state_nxt = S_DRAIN;
          end
        end
      end
      S_CLR: begin
        cnt_nxt = cnt_r + chc_pkg::addr_t'(1);
        if (cnt_r == chc_pkg::ADDR_LAST) begin
          state_nxt = S_IDLE;
        end
      end
      S_DRAIN: begin
        if (pipe_empty && ((func_r == chc_pkg::FUNC_CLEAR) || !out_valid_r)) begin
          unique case (func_r)
            chc_pkg::FUNC_READ: begin
              mul_a_nxt = min_abs;
              state_nxt = S_RMUL;
            end
            chc_pkg::FUNC_CUTS: begin
              cnt_nxt   = '0;
              sum_nxt   = '0;
              state_nxt = S_LO_A;
            end
            default: begin
              cnt_nxt   = '0;
              total_nxt = '0;
              state_nxt = S_CLR;
            end
          endcase
        end
      end
      S_RMUL: begin
        state_nxt = S_RZ;
      end
      S_RZ: begin
        pair_nxt = 1'b0;
        if (chc_pkg::bins_t'(idx_r) >= bins_w) begin
          // A bin beyond the bins in use reads as zero.
          out_load  = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          state_nxt = S_RD1;
          if (!zhit) begin
            fsm_ra = idx_r;
          end else if (zidx == '0) begin
            fsm_ra = chc_pkg::addr_t'(1);
          end else if (zidx == bins_m1) begin
            fsm_ra = bins_m1 - chc_pkg::addr_t'(1);
          end else begin
            // Inner zero bin: read both neighbours and take their mean.
            fsm_ra   = zidx - chc_pkg::addr_t'(1);
            pair_nxt = 1'b1;
            z_nxt    = zidx;
          end
        end
      end
      S_RD1: begin
        fsm_ra = z_r + chc_pkg::addr_t'(1);
        if (pair_r) begin
          acc_nxt   = rd_data_r;
          state_nxt = S_RD2;
        end else begin
          out_load  = 1'b1;
          res_count = rd_data_r;
          state_nxt = S_IDLE;
        end
      end
      S_RD2: begin
        out_load  = 1'b1;
        res_count = chc_pkg::count_t'(({1'b0, acc_r} + {1'b0, rd_data_r}
                                       + 33'd1) >> 1);
        state_nxt = S_IDLE;
      end
      S_LO_A: begin
        fsm_ra    = cnt_r;
        state_nxt = S_LO_B;
      end
      S_LO_B: begin
        sum_nxt = walk_sum;
        if (walk_sum > chc_pkg::sum_t'(cut_lo_r)) begin
          lo_nxt    = (cnt_r == '0) ? '0 : cnt_r - chc_pkg::addr_t'(1);
          cnt_nxt   = '0;
          sum_nxt   = '0;
          state_nxt = S_HI_A;
        end else if (cnt_r == bins_m1) begin
          lo_nxt    = '0;
          cnt_nxt   = '0;
          sum_nxt   = '0;
          state_nxt = S_HI_A;
        end else begin
          cnt_nxt   = cnt_r + chc_pkg::addr_t'(1);
          state_nxt = S_LO_A;
        end
      end
      S_HI_A: begin
        fsm_ra    = hi_j;
        state_nxt = S_HI_B;
      end
      S_HI_B: begin
        sum_nxt = walk_sum;
        res_lo  = lo_r;
        res_cut = ((cut_lo_r != '0) || (cut_hi_r != '0)) &&
                  (cut_sum < {1'b0, total_r});
        if (walk_sum > chc_pkg::sum_t'(cut_hi_r)) begin
          res_hi    = (cnt_r == '0) ? bins_m1 : hi_j + chc_pkg::addr_t'(1);
          out_load  = 1'b1;
          state_nxt = S_IDLE;
        end else if (cnt_r == bins_m1) begin
          res_hi    = bins_m1;
          out_load  = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          cnt_nxt   = cnt_r + chc_pkg::addr_t'(1);
          state_nxt = S_HI_A;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Memory port selection. Adds own the read port while in stage three; the
  // sequencer only runs once they have drained.
  assign mem_ra = vc_r ? add_bin : fsm_ra;
  assign mem_we = (state_r == S_CLR) || vd_r;
  assign mem_wa = (state_r == S_CLR) ? cnt_r : d_addr_r;
  assign mem_wd = (state_r == S_CLR) ? '0 : inc_count;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rd_data_r <= mem[mem_ra];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
      cnt_r   <= '0;
      total_r <= '0;
      vb_r    <= 1'b0;
      vc_r    <= 1'b0;
      vd_r    <= 1'b0;
      fwd_v_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      total_r <= total_nxt;
      vb_r    <= vb_nxt;
      vc_r    <= vb_r;
      vd_r    <= vc_r;
      fwd_v_r <= vd_r;
    end
  end

  always_ff @(posedge clk) begin
    sum_r      <= sum_nxt;
    lo_r       <= lo_nxt;
    acc_r      <= acc_nxt;
    pair_r     <= pair_nxt;
    z_r        <= z_nxt;
    func_r     <= func_nxt;
    idx_r      <= idx_nxt;
    mul_a_r    <= mul_a_nxt;
    prod_r     <= mul_a_r * scale_r;
    d_addr_r   <= add_bin;
    fwd_addr_r <= d_addr_r;
    fwd_data_r <= inc_count;
  end

  // Output register: a finished result waits here until it is taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_count_r <= res_count;
      out_lo_r    <= res_lo;
      out_hi_r    <= res_hi;
      out_cut_r   <= res_cut;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'b000, out_cut_r, out_hi_r, out_lo_r, out_count_r};

  // Configuration registers; indexes beyond the list are ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_r      <= '0;
      scale_r    <= chc_pkg::SCALE_RESET;
      bins_cfg_r <= chc_pkg::BINS_RESET;
      keep_r     <= 1'b1;
      cut_lo_r   <= '0;
      cut_hi_r   <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        chc_pkg::CFG_MIN_VALUE:      min_r      <= cfg_data[31:0];
        chc_pkg::CFG_BIN_SCALE:      scale_r    <= cfg_data[31:0];
        chc_pkg::CFG_BINS_IN_USE:    bins_cfg_r <= cfg_data[chc_pkg::BINS_W-1:0];
        chc_pkg::CFG_KEEP_ZERO_BIN:  keep_r     <= cfg_data[0];
        chc_pkg::CFG_CUT_LOW_COUNT:  cut_lo_r   <= cfg_data[chc_pkg::TOTAL_W-1:0];
        chc_pkg::CFG_CUT_HIGH_COUNT: cut_hi_r   <= cfg_data[chc_pkg::TOTAL_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // The sequencer never touches the memory while adds are in flight.
  `CHC_ASSERT_IMP(a_seq_excludes_adds, (state_r != S_IDLE) && (state_r != S_DRAIN), pipe_empty)
  // A result is only loaded into an empty output register.
  `CHC_ASSERT_IMP(a_out_slot_free, out_load, !out_valid_r)
  // The sample total is zero for the whole clearing sweep.
  `CHC_ASSERT_IMP(a_clear_total_zero, state_r == S_CLR, total_r == '0)
  // The sweep returns to idle after writing the last entry.
  `CHC_ASSERT_NXT(a_clear_ends, (state_r == S_CLR) && (cnt_r == chc_pkg::ADDR_LAST), state_r == S_IDLE)

endmodule

/* tb/sv/clamped_histogram_with_cuts_tb.sv */
// ----------------------------------------------------------------------------
// clamped_histogram_with_cuts_tb
// Self-checking bench for the histogram engine. A scoreboard object keeps its
// own copy of the bin store, the sample total and the registers, works out
// the result word of every accepted read and find-cuts word, and compares
// each result word field by field. Stimulus is a short directed part followed
// by random phases under changing register settings, with bursty input,
// a randomly stalling receiver and long receiver hold-offs.
// ----------------------------------------------------------------------------
module clamped_histogram_with_cuts_tb;
  import chc_pkg::*;

  localparam int HALF_PERIOD    = 5;
  // A clear sweeps all 1024 entries and gives no result word, so an idle
  // engine is only guaranteed after this many cycles with nothing pending.
  localparam int IDLE_CYCLES    = 1200;
  localparam int CYCLE_LIMIT    = 30_000_000;
  localparam int HOLDOFF_CYCLES = 400;
  localparam int MAX_REPORTS    = 100;
  // Index past the last register; the engine must ignore writes to it.
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_IDX = 3'd7;

  // One result word, laid out as out_tdata[52:0].
  typedef struct packed {
    logic        cut_applies;
    addr_t       high_cut_bin;
    addr_t       low_cut_bin;
    count_t      bin_count;
  } hist_word_t;

  // The scoreboard mirrors the engine: bin store, sample total and registers.
  // note_word advances the mirror for each accepted input word and queues the
  // result word it must cause; check_word compares against the oldest one.
  class hist_scoreboard;
    count_t             bin_mem [MAX_BINS];
    total_t             sample_total;
    logic signed [31:0] min_value;
    q_t                 bin_scale;
    bins_t              bins_reg;
    logic               keep_zero_bin;
    total_t             cut_low_count;
    total_t             cut_high_count;
    hist_word_t         expected_words [$];
    int                 mismatches;

    function new();
      foreach (bin_mem[i]) bin_mem[i] = '0;
      sample_total   = '0;
      min_value      = '0;
      bin_scale      = SCALE_RESET;
      bins_reg       = BINS_RESET;
      keep_zero_bin  = 1'b1;
      cut_low_count  = '0;
      cut_high_count = '0;
      mismatches     = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_MIN_VALUE:      min_value      = data[31:0];
        CFG_BIN_SCALE:      bin_scale      = data[31:0];
        CFG_BINS_IN_USE:    bins_reg       = data[BINS_W-1:0];
        CFG_KEEP_ZERO_BIN:  keep_zero_bin  = data[0];
        CFG_CUT_LOW_COUNT:  cut_low_count  = data[TOTAL_W-1:0];
        CFG_CUT_HIGH_COUNT: cut_high_count = data[TOTAL_W-1:0];
        default: ;
      endcase
    endfunction

    // Appends one expected result word behind the ones already waiting.
    function void queue_word(hist_word_t w);
      expected_words.insert(expected_words.size(), w);
    endfunction

    // Out-of-range register values act as the nearest legal bin count.
    function int bins_now();
      if (bins_reg < BINS_MIN) return 2;
      if (bins_reg > BINS_MAX) return MAX_BINS;
      return int'(bins_reg);
    endfunction

    // floor(d * scale + 0.5) for a positive difference, from the exact
    // 64-bit product; neither the product nor the rounding can overflow.
    function longint unsigned scaled_bin(longint unsigned d);
      longint unsigned sc;
      sc = bin_scale;
      return (d * sc + 64'h8000_0000) >> 32;
    endfunction

    // Position of the bin holding the value zero, and whether it lies
    // inside the bins in use. It is never clamped.
    function void zero_bin(output bit ok, output longint unsigned z);
      longint          d;
      longint unsigned mag;
      longint unsigned sc;
      sc = bin_scale;
      ok = 1'b0;
      z  = 0;
      d  = min_value;
      d  = -d;
      if (d == 0 || bin_scale == '0) begin
        ok = 1'b1;
      end else if (d < 0) begin
        // Zero lies below bin zero; it still rounds into bin zero when it is
        // no more than half a bin away.
        mag = -d;
        if (mag * sc <= 64'h8000_0000) ok = 1'b1;
      end else begin
        z  = scaled_bin(d);
        ok = (z < longint'(bins_now()));
      end
    endfunction

    function void note_word(func_t f, logic signed [31:0] sample, addr_t idx);
      hist_word_t      w;
      longint          d;
      longint unsigned b;
      longint unsigned z;
      longint unsigned sum;
      bit              ok;
      int              n;
      int              lo;
      int              hi;
      n = bins_now();
      w = '0;
      case (f)
        FUNC_ADD: begin
          d = sample;
          d = d - min_value;
          b = 0;
          if (d > 0) begin
            b = scaled_bin(d);
            if (b > longint'(n - 1)) b = n - 1;
          end
          if (bin_mem[b] != '1) bin_mem[b] = bin_mem[b] + 1'b1;
          if (sample_total != '1) sample_total = sample_total + 1'b1;
        end
        FUNC_READ: begin
          zero_bin(ok, z);
          if (int'(idx) >= n) begin
            w.bin_count = '0;
          end else if (keep_zero_bin || !ok || z != idx) begin
            w.bin_count = bin_mem[idx];
          end else if (z == 0) begin
            w.bin_count = bin_mem[1];
          end else if (z == longint'(n - 1)) begin
            w.bin_count = bin_mem[n - 2];
          end else begin
            // Inner zero bin: rounded mean of its two neighbours.
            sum = bin_mem[z - 1];
            sum = sum + bin_mem[z + 1] + 1;
            w.bin_count = count_t'(sum >> 1);
          end
          queue_word(w);
        end
        FUNC_CUTS: begin
          lo  = 0;
          hi  = n - 1;
          sum = 0;
          for (int t = 0; t < n; t++) begin
            sum = sum + bin_mem[t];
            if (sum > cut_low_count) begin
              if (t > 0) lo = t - 1;
              break;
            end
          end
          sum = 0;
          for (int t = n; t > 0; t--) begin
            sum = sum + bin_mem[t - 1];
            if (sum > cut_high_count) begin
              if (t - 1 < n - 1) hi = t;
              break;
            end
          end
          w.low_cut_bin  = addr_t'(lo);
          w.high_cut_bin = addr_t'(hi);
          w.cut_applies  = (cut_low_count != '0 || cut_high_count != '0) &&
                           ({1'b0, cut_low_count} + {1'b0, cut_high_count} <
                            {1'b0, sample_total});
          queue_word(w);
        end
        default: begin
          foreach (bin_mem[i]) bin_mem[i] = '0;
          sample_total = '0;
        end
      endcase
    endfunction

    function void flag(string field, logic [63:0] want, logic [63:0] got);
      mismatches++;
      if (mismatches <= MAX_REPORTS)
        $error("%s: expected 0x%0h, actual 0x%0h", field, want, got);
    endfunction

    function void check_word(logic [OUT_DATA_W-1:0] data);
      hist_word_t got;
      hist_word_t want;
      got = data[$bits(hist_word_t)-1:0];
      if (expected_words.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $error("result word 0x%0h arrived with no expectation waiting", data);
        return;
      end
      want = expected_words.pop_front();
      if (got.bin_count !== want.bin_count)
        flag("bin_count", want.bin_count, got.bin_count);
      if (got.low_cut_bin !== want.low_cut_bin)
        flag("low_cut_bin", want.low_cut_bin, got.low_cut_bin);
      if (got.high_cut_bin !== want.high_cut_bin)
        flag("high_cut_bin", want.high_cut_bin, got.high_cut_bin);
      if (got.cut_applies !== want.cut_applies)
        flag("cut_applies", want.cut_applies, got.cut_applies);
    endfunction

    function int pending();
      return expected_words.size();
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;
  logic [1:0]            in_tuser;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  hist_scoreboard sb;

  // Sender shaping: words left in the current burst and the longest gap.
  int burst_left = 0;
  int gap_max    = 8;

  // Receiver state. Toggling holdoff_req asks the receiver for one long
  // hold-off, which it counts out by itself.
  bit holdoff_req  = 1'b0;
  bit holdoff_seen = 1'b0;
  int hold_left    = 0;
  int mode_left    = 0;
  int ready_pct    = 100;
  int cycle_count  = 0;

  clamped_histogram_with_cuts i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #HALF_PERIOD clk = ~clk;

  // Run limit. A healthy run stays far below it even if every word were a
  // find-cuts walk over all 1024 bins behind a stalled receiver.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("[clamped_histogram_with_cuts] ERROR");
      $finish;
    end
  end

  // Receiver. Outside a hold-off it switches at random intervals between patterns:
  // always ready, mostly ready, half ready and mostly stalled.
  always @(posedge clk) begin
    if (hold_left > 0) begin
      hold_left  <= hold_left - 1;
      out_tready <= 1'b0;
    end else if (holdoff_req != holdoff_seen) begin
      holdoff_seen <= holdoff_req;
      hold_left    <= HOLDOFF_CYCLES;
      out_tready   <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        mode_left <= $urandom_range(16, 128);
        case ($urandom_range(0, 3))
          0:       ready_pct <= 100;
          1:       ready_pct <= 85;
          2:       ready_pct <= 50;
          default: ready_pct <= 20;
        endcase
      end else begin
        mode_left <= mode_left - 1;
      end
      out_tready <= ($urandom_range(0, 99) < ready_pct);
    end
  end

  // Every accepted result word is checked against the oldest expectation.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_word(out_tdata);
  end

  // Offers one input word and returns once it has been accepted. A new
  // burst starts with a random gap, sometimes none at all.
  task automatic put_word(func_t f, logic [31:0] smp, addr_t idx);
    int gap;
    if (burst_left == 0) begin
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, gap_max);
      burst_left = $urandom_range(1, 48);
      if (gap != 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tuser  <= f;
    in_tdata  <= {6'b0, idx, smp};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_word(f, smp, idx);
  endtask

  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.write_reg(idx, data);
  endtask

  // Stops offering words, waits for all expected result words and then
  // lets the engine finish any clear sweep still in progress.
  task automatic settle();
    in_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (IDLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic [CFG_DATA_W-1:0] rand40();
    logic [63:0] w;
    w = {$urandom, $urandom};
    return w[CFG_DATA_W-1:0];
  endfunction

  // Mostly samples spread a little beyond the bins in use on both sides,
  // so that both clamps are hit; one in ten is an arbitrary value.
  function automatic logic [31:0] pick_sample();
    longint unsigned span;
    longint unsigned r;
    longint          d;
    if ($urandom_range(0, 9) == 0) return $urandom;
    if (sb.bin_scale == '0) begin
      span = 64'h8000_0000;
    end else begin
      span = sb.bins_now();
      span = (span << 32) / sb.bin_scale;
      if (span > 64'h8000_0000) span = 64'h8000_0000;
      if (span == 0) span = 1;
    end
    r = $urandom;
    r = (r * (span + span / 4)) >> 32;
    d = r;
    d = d - longint'(span / 8);
    d = d + sb.min_value;
    return d[31:0];
  endfunction

  // Writes every register with a fresh setting; unused data bits are random.
  task automatic random_setup();
    logic [CFG_DATA_W-1:0] fill;
    logic [31:0]           mn;
    logic [31:0]           sc;
    logic [BINS_W-1:0]     nb;
    logic [CFG_DATA_W-1:0] cl;
    logic [CFG_DATA_W-1:0] ch;
    case ($urandom_range(0, 9))
      0:       nb = 2;
      1:       nb = MAX_BINS;
      2:       nb = $urandom_range(0, 1) ? $urandom_range(0, 1) : $urandom_range(1025, 2047);
      3:       nb = $urandom_range(2, 1024);
      default: nb = $urandom_range(2, 40);
    endcase
    case ($urandom_range(0, 7))
      0:       mn = 32'h0000_0000;
      1:       mn = 32'h8000_0000;
      2:       mn = 32'h7FFF_FFFF;
      3, 4:    mn = $urandom;
      default: mn = $urandom_range(0, 64 << 16) - (32 << 16);
    endcase
    case ($urandom_range(0, 9))
      0:       sc = 32'h0000_0000;
      1:       sc = 32'hFFFF_FFFF;
      2, 3:    sc = SCALE_RESET;
      4, 5:    sc = $urandom;
      default: begin
        sc = 32'd1 << $urandom_range(12, 20);
        sc = sc | $urandom_range(0, 4095);
      end
    endcase
    case ($urandom_range(0, 5))
      0:       cl = '0;
      1:       cl = '1;
      2:       cl = rand40();
      default: cl = $urandom_range(0, 80);
    endcase
    case ($urandom_range(0, 5))
      0:       ch = '0;
      1:       ch = '1;
      2:       ch = rand40();
      default: ch = $urandom_range(0, 80);
    endcase
    fill = rand40();
    cfg_write(CFG_MIN_VALUE, {fill[39:32], mn});
    fill = rand40();
    cfg_write(CFG_BIN_SCALE, {fill[39:32], sc});
    fill = rand40();
    cfg_write(CFG_BINS_IN_USE, {fill[39:BINS_W], nb});
    fill = rand40();
    cfg_write(CFG_KEEP_ZERO_BIN, fill);
    cfg_write(CFG_CUT_LOW_COUNT, cl);
    cfg_write(CFG_CUT_HIGH_COUNT, ch);
    if ($urandom_range(0, 2) == 0) cfg_write(CFG_SPARE_IDX, rand40());
    cfg_valid <= 1'b0;
  endtask

  // Random words under the current setting. Reads aim at the zero bin and its lower
  // neighbour, the last bin in use and, now and then, past the bins in use.
  task automatic random_phase(int n_items, int read_pct, int cuts_pct);
    int              r;
    int              n;
    func_t           f;
    addr_t           idx;
    bit              ok;
    longint unsigned z;
    for (int k = 0; k < n_items; k++) begin
      n = sb.bins_now();
      r = $urandom_range(0, 99);
      if (r < read_pct) f = FUNC_READ;
      else if (r < read_pct + cuts_pct) f = FUNC_CUTS;
      else if (r == 99) f = FUNC_CLEAR;
      else f = FUNC_ADD;
      sb.zero_bin(ok, z);
      r = $urandom_range(0, 9);
      if (r == 0 && ok) idx = addr_t'(z);
      else if (r == 1 && ok && z > 0) idx = addr_t'(z - 1);
      else if (r == 2) idx = addr_t'($urandom);
      else if (r == 3) idx = addr_t'(n - 1);
      else idx = addr_t'($urandom_range(0, n - 1));
      put_word(f, pick_sample(), idx);
    end
  endtask

  initial begin
    sb = new();
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    in_tuser  <= FUNC_ADD;
    cfg_valid <= 1'b0;
    cfg_index <= CFG_MIN_VALUE;
    cfg_data  <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Reset setting: both sample extremes, rounding exactly at and just
    // below half a bin, reads at both ends and past the bins in use, a cut
    // walk with no cut set, and a clear followed by a read.
    put_word(FUNC_ADD, 32'h7FFF_FFFF, 10'd0);
    put_word(FUNC_ADD, 32'h8000_0000, 10'd0);
    put_word(FUNC_ADD, 32'h0000_8000, 10'd0);
    put_word(FUNC_ADD, 32'h0000_7FFF, 10'd0);
    put_word(FUNC_READ, 32'h0, 10'd0);
    put_word(FUNC_READ, 32'h0, 10'd1);
    put_word(FUNC_READ, 32'h0, 10'd255);
    put_word(FUNC_READ, 32'h0, 10'd1023);
    put_word(FUNC_CUTS, 32'h0, 10'd0);
    put_word(FUNC_CLEAR, 32'h0, 10'd0);
    put_word(FUNC_READ, 32'h0, 10'd0);
    settle();

    // Eight bins with zero at bin three: the zero bin reads as the mean of
    // its neighbours, and both cut walks cross.
    cfg_write(CFG_MIN_VALUE, 40'h00_FFFD_8000);
    cfg_write(CFG_BINS_IN_USE, 40'd8);
    cfg_write(CFG_KEEP_ZERO_BIN, 40'd0);
    cfg_write(CFG_CUT_LOW_COUNT, 40'd1);
    cfg_write(CFG_CUT_HIGH_COUNT, 40'd1);
    cfg_write(CFG_SPARE_IDX, '1);
    cfg_valid <= 1'b0;
    put_word(FUNC_ADD, 32'hFFFF_8000, 10'd0);
    put_word(FUNC_ADD, 32'h0000_0000, 10'd0);
    put_word(FUNC_ADD, 32'h0001_8000, 10'd0);
    put_word(FUNC_ADD, 32'h0001_8000, 10'd0);
    put_word(FUNC_READ, 32'h0, 10'd3);
    put_word(FUNC_CUTS, 32'h0, 10'd0);
    settle();

    // Largest minimum and scale, bins register above its range, cut counts
    // that are never exceeded, zero bin far below the histogram.
    cfg_write(CFG_MIN_VALUE, 40'hFF_7FFF_FFFF);
    cfg_write(CFG_BIN_SCALE, 40'hFF_FFFF_FFFF);
    cfg_write(CFG_BINS_IN_USE, 40'd2047);
    cfg_write(CFG_CUT_LOW_COUNT, '1);
    cfg_write(CFG_CUT_HIGH_COUNT, '1);
    cfg_valid <= 1'b0;
    put_word(FUNC_ADD, 32'h8000_0000, 10'd0);
    put_word(FUNC_ADD, 32'h7FFF_FFFF, 10'd0);
    put_word(FUNC_READ, 32'h0, 10'd0);
    put_word(FUNC_CUTS, 32'h0, 10'd0);
    settle();

    // Smallest minimum, zero scale and bins register below its range: every
    // sample lands in bin zero, which then reads as bin one.
    cfg_write(CFG_MIN_VALUE, 40'h00_8000_0000);
    cfg_write(CFG_BIN_SCALE, 40'd0);
    cfg_write(CFG_BINS_IN_USE, 40'd0);
    cfg_write(CFG_CUT_LOW_COUNT, 40'd0);
    cfg_write(CFG_CUT_HIGH_COUNT, 40'd0);
    cfg_valid <= 1'b0;
    put_word(FUNC_ADD, 32'h7FFF_FFFF, 10'd0);
    put_word(FUNC_READ, 32'h0, 10'd0);
    put_word(FUNC_READ, 32'h0, 10'd1);

    // Random phases. Two of them are read-heavy and start a long receiver
    // hold-off, so the output register stays full and the input stalls.
    // Every fourth phase sends without gaps.
    for (int p = 0; p < 10; p++) begin
      settle();
      random_setup();
      gap_max = (p % 4 == 3) ? 0 : 8;
      if (p == 2 || p == 6) begin
        holdoff_req <= ~holdoff_req;
        random_phase(160, 35, 2);
      end else begin
        random_phase($urandom_range(120, 200), 10, (sb.bins_now() > 256) ? 1 : 3);
      end
    end
    settle();

    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("[clamped_histogram_with_cuts] OK");
    end else begin
      $display("[clamped_histogram_with_cuts] ERROR");
    end
    $finish;
  end

endmodule

/* files.f */
+incdir+rtl/core
rtl/core/chc_pkg.sv
rtl/core/clamped_histogram_with_cuts.sv
tb/sv/clamped_histogram_with_cuts_tb.sv
